@@ rtl/core/nltr_pkg.sv @@
package nltr_pkg;

  // Input beat kinds.
  typedef enum logic {
    KIND_UPDATE  = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_t;

  // Result actions.
  typedef enum logic [2:0] {
    ACT_UPDATED  = 3'd0,
    ACT_APPENDED = 3'd1,
    ACT_DROPPED  = 3'd2,
    ACT_SELF     = 3'd3,
    ACT_LOCAL    = 3'd4,
    ACT_FORWARD  = 3'd5,
    ACT_REDIRECT = 3'd6
  } action_t;

  // Input beat payload.
  typedef struct packed {
    logic        kind;
    logic [31:0] node_id;
    logic [15:0] total_cores;
    logic [15:0] busy_cores;
  } in_item_t;

  // Result beat payload.
  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] target_node;
  } out_item_t;

  // One row of the neighbour table.
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] total_cores;
    logic [15:0] busy_cores;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic issue;
    logic finish;
  } nltr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic self_hit;
    logic tbl_empty;
    logic last_issue;
    logic out_free;
  } nltr_sts_t;

endpackage

@@ rtl/core/nltr_ram.sv @@
module nltr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/nltr_ctrl.sv @@
module nltr_ctrl
  import nltr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  nltr_sts_t sts,
  output logic      in_ready,
  output nltr_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.self_hit || sts.tbl_empty) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = 1'b0;
    cmd.load_item = 1'b0;
    cmd.issue     = 1'b0;
    cmd.finish    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/nltr_dp.sv @@
module nltr_dp
  import nltr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        out_ready,
  input  nltr_cmd_t   cmd,
  output nltr_sts_t   sts,
  output logic        out_valid,
  output out_item_t   out_item
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  in_item_t         item_r;
  logic [31:0]      own_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             match_r;
  logic [IDX_W-1:0] match_idx_r;
  logic             match_full_r;
  logic [15:0]      min_busy_r;
  logic [31:0]      min_id_r;
  out_item_t        out_r;
  logic             out_valid_r;

  entry_t           rd_entry;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             tbl_full;
  out_item_t        res;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= '0;
    end else if (cfg_wr_en) begin
      own_r <= cfg_wr_data;
    end
  end

  // Captured input beat.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
  end

  assign tbl_full = (count_r == CNT_W'(TABLE_DEPTH));

  assign sts.self_hit   = (item_r.node_id == own_r);
  assign sts.tbl_empty  = (count_r == '0);
  assign sts.last_issue = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  // Scan address counter and read pipeline tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.load_item) begin
        idx_r <= '0;
      end else if (cmd.issue) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_idx_r <= idx_r;
    end
  end

  // First match and first minimum of busy cores, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (cmd.load_item) begin
      match_r <= 1'b0;
    end else if (rd_vld_r && !match_r && rd_entry.id == item_r.node_id) begin
      match_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (!match_r && rd_entry.id == item_r.node_id) begin
        match_idx_r  <= rd_idx_r;
        match_full_r <= (rd_entry.total_cores == rd_entry.busy_cores);
      end
      if (rd_idx_r == '0 || rd_entry.busy_cores < min_busy_r) begin
        min_busy_r <= rd_entry.busy_cores;
        min_id_r   <= rd_entry.id;
      end
    end
  end

  // Result selection and table write.
  always_comb begin
    res.action      = ACT_FORWARD;
    res.target_node = item_r.node_id;
    ram_we          = 1'b0;
    ram_waddr       = match_idx_r;
    if (item_r.kind == KIND_UPDATE) begin
      if (sts.self_hit) begin
        res.action = ACT_SELF;
      end else if (match_r) begin
        res.action = ACT_UPDATED;
        ram_we     = cmd.finish;
      end else if (!tbl_full) begin
        res.action = ACT_APPENDED;
        ram_we     = cmd.finish;
        ram_waddr  = count_r[IDX_W-1:0];
      end else begin
        res.action = ACT_DROPPED;
      end
    end else begin
      if (sts.self_hit) begin
        res.action      = ACT_LOCAL;
        res.target_node = own_r;
      end else if (match_r && match_full_r) begin
        res.action      = ACT_REDIRECT;
        res.target_node = min_id_r;
      end
    end
  end

  // Entry count grows on each append.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ram_we && !match_r) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  nltr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({item_r.node_id, item_r.total_cores, item_r.busy_cores}),
    .re    (cmd.issue),
    .raddr (idx_r),
    .rdata (rd_entry)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

@@ rtl/core/neighbour_load_table_redirect_unit.sv @@
// Channel  Ports                         Beat
// -------  ----------------------------  -----------------------------------
// input    in_valid/in_ready/in_item     one update or execution request
// result   out_valid/out_ready/out_item  one action and target node per beat
// config   cfg_wr_en/cfg_wr_data         own node id, written at once
//
// An item runs through the check, scan (N table entries), drain and finish
// states; with an empty table or the own id it goes from check to finish.
// The scan reads one table entry per cycle from the single RAM read port.
// Reset clears the entry count, the own id and the handshakes; the table
// itself needs no clearing pass, since only entries below the count are read.
// A stalled result waits in the output register; the next beat may be taken
// meanwhile, and only its own finish waits for the register to drain.
module neighbour_load_table_redirect_unit
  import nltr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  nltr_cmd_t cmd;
  nltr_sts_t sts;

  nltr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  nltr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

  // One beat at a time: a new beat is never taken right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // A result is only loaded when the output register is free.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result overwrote a pending beat");

  // Every finished item shows up as a result beat.
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finished item produced no result beat");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import nltr_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 16;
  localparam int unsigned POOL_SIZE      = 24;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  // Shadow copy of the neighbour table and the own id.
  logic [31:0] own_id;
  logic [31:0] nbr_id    [TABLE_DEPTH];
  logic [15:0] nbr_total [TABLE_DEPTH];
  logic [15:0] nbr_busy  [TABLE_DEPTH];
  int          nbr_count;

  // Actions still owed by the block, oldest first.
  out_item_t   expected_actions[$];
  out_item_t   expected_beat;

  logic [31:0] node_pool [POOL_SIZE];
  int unsigned err_count;
  int unsigned burst_left;
  int unsigned idle_cycles;
  logic        hold_pending;

  neighbour_load_table_redirect_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    err_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Applies one accepted beat to the shadow table and returns the action it causes.
  function automatic out_item_t predict_action(input in_item_t beat);
    out_item_t res;
    int        hit;
    int        best;
    int        i;
    res.action      = ACT_FORWARD;
    res.target_node = beat.node_id;
    hit = -1;
    for (i = 0; i < nbr_count; i++) begin
      if (hit < 0 && nbr_id[i] == beat.node_id) hit = i;
    end
    if (beat.kind == KIND_UPDATE) begin
      if (beat.node_id == own_id) begin
        res.action = ACT_SELF;
      end else if (hit >= 0) begin
        nbr_total[hit] = beat.total_cores;
        nbr_busy[hit]  = beat.busy_cores;
        res.action     = ACT_UPDATED;
      end else if (nbr_count < TABLE_DEPTH) begin
        nbr_id[nbr_count]    = beat.node_id;
        nbr_total[nbr_count] = beat.total_cores;
        nbr_busy[nbr_count]  = beat.busy_cores;
        nbr_count++;
        res.action = ACT_APPENDED;
      end else begin
        res.action = ACT_DROPPED;
      end
    end else if (beat.node_id == own_id) begin
      res.action      = ACT_LOCAL;
      res.target_node = own_id;
    end else if (hit >= 0 && nbr_total[hit] == nbr_busy[hit]) begin
      // Overloaded neighbour: pick the first entry with the fewest busy cores.
      best = 0;
      for (i = 1; i < nbr_count; i++) begin
        if (nbr_busy[i] < nbr_busy[best]) best = i;
      end
      res.action      = ACT_REDIRECT;
      res.target_node = nbr_id[best];
    end
    return res;
  endfunction

  function automatic in_item_t make_beat(input kind_t k, input logic [31:0] id,
                                         input logic [15:0] total,
                                         input logic [15:0] busy);
    in_item_t b;
    b.kind        = k;
    b.node_id     = id;
    b.total_cores = total;
    b.busy_cores  = busy;
    return b;
  endfunction

  // Mostly known neighbours, with small core counts so that ties and overloads are common.
  function automatic in_item_t random_beat();
    in_item_t    b;
    int unsigned pick;
    b.kind = 1'($urandom_range(0, 1));
    pick   = $urandom_range(0, 9);
    if (pick < 7) begin
      b.node_id = node_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (pick == 7) begin
      b.node_id = own_id;
    end else begin
      b.node_id = $urandom;
    end
    if ($urandom_range(0, 1) == 1) begin
      b.total_cores = 16'($urandom_range(0, 3));
    end else begin
      b.total_cores = 16'($urandom);
    end
    case ($urandom_range(0, 2))
      0: begin
        b.busy_cores = b.total_cores;
      end
      1: begin
        b.busy_cores = 16'($urandom_range(0, 3));
      end
      default: begin
        b.busy_cores = 16'($urandom);
      end
    endcase
    return b;
  endfunction

  // Offers one beat, in bursts with random gaps, and records its action once accepted.
  task automatic send_beat(input in_item_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_actions.insert(expected_actions.size(), predict_action(beat));
  endtask

  // Stops offering and lets the block finish every outstanding beat.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic set_own_id(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    own_id = value;
  endtask

  // Empty table with the own id at its reset value.
  task automatic test_empty_table();
    send_beat(make_beat(KIND_REQUEST, 32'd5, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(KIND_REQUEST, 32'd0, 16'h0000, 16'h0000));
    send_beat(make_beat(KIND_UPDATE, 32'd0, 16'hFFFF, 16'hFFFF));
  endtask

  // Appends, updates, overloads, redirects (to the destination itself too) and forwards.
  task automatic test_append_and_redirect();
    send_beat(make_beat(KIND_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(KIND_UPDATE, 32'd1, 16'h0000, 16'h0000));
    send_beat(make_beat(KIND_REQUEST, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF));
    send_beat(make_beat(KIND_REQUEST, 32'd1, 16'hFFFF, 16'h0000));
    send_beat(make_beat(KIND_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000));
    send_beat(make_beat(KIND_REQUEST, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(KIND_REQUEST, 32'd1, 16'h0000, 16'h0000));
    send_beat(make_beat(KIND_REQUEST, 32'd7, 16'hFFFF, 16'hFFFF));
  endtask

  // The own id also sits in the table: requests run locally, updates are ignored.
  task automatic test_own_id_in_table();
    wait_idle();
    set_own_id(32'hFFFF_FFFF);
    send_beat(make_beat(KIND_REQUEST, 32'hFFFF_FFFF, 16'h0000, 16'h0000));
    send_beat(make_beat(KIND_UPDATE, 32'hFFFF_FFFF, 16'h1234, 16'h1234));
    send_beat(make_beat(KIND_REQUEST, 32'd1, 16'h5555, 16'hAAAA));
  endtask

  // Random traffic under several own ids; the table fills and later updates drop.
  task automatic test_random_phases();
    logic [31:0] settings [5];
    int          p;
    int          n;
    for (p = 0; p < POOL_SIZE; p++) node_pool[p] = $urandom;
    node_pool[0] = 32'd1;
    node_pool[1] = 32'hFFFF_FFFF;
    node_pool[2] = 32'h8000_0000;
    node_pool[3] = 32'h0000_0000;
    settings[0] = 32'h0000_0000;
    settings[1] = node_pool[$urandom_range(0, POOL_SIZE - 1)];
    settings[2] = $urandom;
    settings[3] = 32'hFFFF_FFFF;
    settings[4] = node_pool[$urandom_range(0, POOL_SIZE - 1)];
    for (p = 0; p < 5; p++) begin
      wait_idle();
      set_own_id(settings[p]);
      for (n = 0; n < 100; n++) send_beat(random_beat());
    end
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_output_backpressure();
    int n;
    wait_idle();
    set_own_id($urandom);
    hold_pending <= 1'b1;
    for (n = 0; n < 40; n++) send_beat(random_beat());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    hold_pending = 1'b0;
    own_id       = '0;
    nbr_count    = 0;
    err_count    = 0;
    burst_left   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_append_and_redirect();
    test_own_id_in_table();
    test_random_phases();
    test_output_backpressure();
    wait_idle();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: switches between random ready patterns, or holds off on request.
  initial begin : rx_pattern
    int unsigned mode;
    int unsigned left;
    out_ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending <= 1'b0;
        out_ready    <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(4, 40);
      end
      left--;
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          out_ready <= ($urandom_range(0, 4) == 0);
        end
        default: begin
          out_ready <= ~out_ready;
        end
      endcase
    end
  end

  // Compares each result beat with the oldest outstanding action.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_actions.size() == 0) begin
        report_mismatch($sformatf("result beat action=%0d target=%h with nothing expected",
                                  out_item.action, out_item.target_node));
      end else begin
        expected_beat = expected_actions.pop_front();
        if (out_item.action !== expected_beat.action) begin
          report_mismatch($sformatf("action got %0d want %0d (target want %h)",
                                    out_item.action, expected_beat.action,
                                    expected_beat.target_node));
        end
        if (out_item.target_node !== expected_beat.target_node) begin
          report_mismatch($sformatf("target_node got %h want %h (action %0d)",
                                    out_item.target_node, expected_beat.target_node,
                                    expected_beat.action));
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
